FILE: hw/rtl/cie_pkg.sv
// Shared opcodes, status codes, request record and helpers for the COMET execute unit.
package cie_pkg;

  localparam int MEM_WORDS_DEF = 65536;

  localparam logic [7:0] OP_LD   = 8'h10;
  localparam logic [7:0] OP_ST   = 8'h11;
  localparam logic [7:0] OP_LEA  = 8'h12;
  localparam logic [7:0] OP_ADD  = 8'h20;
  localparam logic [7:0] OP_SUB  = 8'h21;
  localparam logic [7:0] OP_AND  = 8'h30;
  localparam logic [7:0] OP_OR   = 8'h31;
  localparam logic [7:0] OP_EOR  = 8'h32;
  localparam logic [7:0] OP_CPA  = 8'h40;
  localparam logic [7:0] OP_CPL  = 8'h41;
  localparam logic [7:0] OP_SLA  = 8'h50;
  localparam logic [7:0] OP_SRA  = 8'h51;
  localparam logic [7:0] OP_SLL  = 8'h52;
  localparam logic [7:0] OP_SRL  = 8'h53;
  localparam logic [7:0] OP_JPZ  = 8'h60;
  localparam logic [7:0] OP_JMI  = 8'h61;
  localparam logic [7:0] OP_JNZ  = 8'h62;
  localparam logic [7:0] OP_JZE  = 8'h63;
  localparam logic [7:0] OP_JMP  = 8'h64;
  localparam logic [7:0] OP_PUSH = 8'h70;
  localparam logic [7:0] OP_POP  = 8'h71;
  localparam logic [7:0] OP_CALL = 8'h80;
  localparam logic [7:0] OP_RET  = 8'h81;

  localparam logic REQ_WRITE = 1'b0;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_BADREG = 2'd1;
  localparam logic [1:0] STAT_BADOP  = 2'd2;
  localparam logic [1:0] STAT_PCOUT  = 2'd3;

  localparam logic [1:0] FLAG_POS  = 2'd0;
  localparam logic [1:0] FLAG_ZERO = 2'd1;
  localparam logic [1:0] FLAG_NEG  = 2'd2;

  localparam logic [15:0] EXIT_ADR  = 16'hF0B0;
  localparam logic [15:0] SIGN_MASK = 16'h8000;
  localparam logic [15:0] MAG_MASK  = 16'h7FFF;
  localparam logic [3:0]  SP_IDX    = 4'd4;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  opcode;
    logic [3:0]  reg_sel;
    logic [3:0]  index_sel;
    logic        uses_x;
    logic [1:0]  status;
    logic [15:0] adr_word;
    logic [15:0] load_data;
  } req_t;

  function automatic logic [1:0] flag_of(input logic [15:0] v);
    if (v == 16'd0) return FLAG_ZERO;
    return ((v & SIGN_MASK) != 16'd0) ? FLAG_NEG : FLAG_POS;
  endfunction

endpackage

FILE: hw/rtl/cie_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cie_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/cie_front.sv
// Front end: accepts requests, checks opcode and register fields, queues them.
module cie_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  logic [7:0]        opcode,
  input  logic [3:0]        reg_sel,
  input  logic [3:0]        index_sel,
  input  logic [15:0]       adr_word,
  input  logic [15:0]       load_data,
  output logic              q_valid,
  input  logic              q_ready,
  output cie_pkg::req_t     q_item
);

  cie_pkg::req_t slots [2];
  cie_pkg::req_t dec;
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;
  logic          known, uses_r, uses_x;
  logic          push, pop;

  always_comb begin
    known  = 1'b1;
    uses_r = 1'b0;
    uses_x = 1'b1;
    unique case (opcode) inside
      cie_pkg::OP_LD, cie_pkg::OP_ST, cie_pkg::OP_LEA, cie_pkg::OP_ADD,
      cie_pkg::OP_SUB, cie_pkg::OP_AND, cie_pkg::OP_OR, cie_pkg::OP_EOR,
      cie_pkg::OP_CPA, cie_pkg::OP_CPL, cie_pkg::OP_SLA, cie_pkg::OP_SRA,
      cie_pkg::OP_SLL, cie_pkg::OP_SRL: uses_r = 1'b1;
      cie_pkg::OP_POP: begin
        uses_r = 1'b1;
        uses_x = 1'b0;
      end
      cie_pkg::OP_RET: uses_x = 1'b0;
      cie_pkg::OP_JPZ, cie_pkg::OP_JMI, cie_pkg::OP_JNZ, cie_pkg::OP_JZE,
      cie_pkg::OP_JMP, cie_pkg::OP_PUSH, cie_pkg::OP_CALL: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  always_comb begin
    dec.req_type  = req_type;
    dec.opcode    = opcode;
    dec.reg_sel   = reg_sel;
    dec.index_sel = index_sel;
    dec.uses_x    = uses_x;
    dec.adr_word  = adr_word;
    dec.load_data = load_data;
    if (req_type == cie_pkg::REQ_WRITE) begin
      dec.status = cie_pkg::STAT_OK;
    end else if (!known) begin
      dec.status = cie_pkg::STAT_BADOP;
    end else if ((uses_r && reg_sel > cie_pkg::SP_IDX) ||
                 (uses_x && index_sel > cie_pkg::SP_IDX)) begin
      dec.status = cie_pkg::STAT_BADREG;
    end else begin
      dec.status = cie_pkg::STAT_OK;
    end
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= dec;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("request queue overfilled");

endmodule

FILE: hw/rtl/cie_back.sv
// Back end: register file, memory, flag and pc; executes one queued request at a time.
module cie_back #(
  parameter int MEM_WORDS = cie_pkg::MEM_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  cie_pkg::req_t     q_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [15:0]       next_pc,
  output logic [1:0]        flag_out,
  output logic              exit_seen,
  output logic              mem_written,
  output logic [15:0]       mem_addr,
  output logic [15:0]       mem_data
);

  localparam int AW = $clog2(MEM_WORDS);

  typedef enum logic [1:0] {
    ST_FETCH = 2'b01,
    ST_EXEC  = 2'b10
  } state_t;

  state_t        state;
  cie_pkg::req_t cur;
  logic [15:0]   regs [5];
  logic [15:0]   regs_next [5];
  logic [1:0]    flag, flag_next;
  logic [15:0]   pc, pc_next;
  logic [15:0]   ea, ea_c, g, g_c, rd_addr_c;
  logic          rd_ok;
  logic [15:0]   rdata, m;
  logic          commit;
  logic          wr_en;
  logic [15:0]   wr_addr, wr_data, res;
  logic [1:0]    st_c;
  logic          exit_c;
  logic [15:0]   sp_dec, sp_inc, pc_step, rsel_wide;
  logic [2:0]    r3;
  logic [3:0]    sra_n;

  function automatic logic [15:0] reg_rd(input logic [15:0] rf [5], input logic [3:0] idx);
    case (idx)
      4'd0:    return rf[0];
      4'd1:    return rf[1];
      4'd2:    return rf[2];
      4'd3:    return rf[3];
      4'd4:    return rf[4];
      default: return 16'd0;
    endcase
  endfunction

  function automatic logic in_mem(input logic [15:0] a);
    return {1'b0, a} < 17'(MEM_WORDS);
  endfunction

  // Fetch phase: form the effective address and start the operand read.
  always_comb begin
    ea_c = q_item.adr_word;
    if (q_item.uses_x && q_item.index_sel != 4'd0) begin
      ea_c = q_item.adr_word + reg_rd(regs, q_item.index_sel);
    end
    g_c = reg_rd(regs, q_item.reg_sel);
    if (q_item.opcode == cie_pkg::OP_POP || q_item.opcode == cie_pkg::OP_RET) begin
      rd_addr_c = regs[4];
    end else begin
      rd_addr_c = ea_c;
    end
  end

  assign q_ready = (state == ST_FETCH);
  assign commit  = (state == ST_EXEC) && (!out_valid || out_ready);

  cie_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (commit && wr_en),
    .waddr (wr_addr[AW-1:0]),
    .wdata (wr_data),
    .re    (q_valid && q_ready),
    .raddr (rd_addr_c[AW-1:0]),
    .rdata (rdata)
  );

  assign m       = rd_ok ? rdata : 16'd0;
  assign sp_dec  = regs[4] - 16'd1;
  assign sp_inc  = regs[4] + 16'd1;
  assign pc_step = pc + 16'd2;
  assign r3      = cur.reg_sel[2:0];
  assign sra_n   = (ea > 16'd15) ? 4'd15 : ea[3:0];
  assign rsel_wide = 16'(cur.reg_sel);

  // Execute phase.
  always_comb begin
    for (int i = 0; i < 5; i++) regs_next[i] = regs[i];
    flag_next = flag;
    pc_next   = pc;
    st_c      = cur.status;
    exit_c    = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = cur.adr_word;
    wr_data   = cur.load_data;
    res       = 16'd0;
    if (cur.req_type == cie_pkg::REQ_WRITE) begin
      wr_en = in_mem(cur.adr_word);
    end else if (cur.status == cie_pkg::STAT_OK) begin
      st_c = in_mem(pc) ? cie_pkg::STAT_OK : cie_pkg::STAT_PCOUT;
      if (in_mem(pc)) pc_next = pc_step;
      case (cur.opcode)
        cie_pkg::OP_LD:  regs_next[r3] = m;
        cie_pkg::OP_ST: begin
          wr_en   = in_mem(ea);
          wr_addr = ea;
          wr_data = g;
        end
        cie_pkg::OP_LEA, cie_pkg::OP_ADD, cie_pkg::OP_SUB, cie_pkg::OP_AND,
        cie_pkg::OP_OR, cie_pkg::OP_EOR, cie_pkg::OP_SLA, cie_pkg::OP_SRA,
        cie_pkg::OP_SLL, cie_pkg::OP_SRL: begin
          case (cur.opcode)
            cie_pkg::OP_LEA: res = ea;
            cie_pkg::OP_ADD: res = g + m;
            cie_pkg::OP_SUB: res = g - m;
            cie_pkg::OP_AND: res = g & m;
            cie_pkg::OP_OR:  res = g | m;
            cie_pkg::OP_EOR: res = g ^ m;
            cie_pkg::OP_SLA:
              res = ((ea > 16'd15) ? 16'd0 : ((g << ea[3:0]) & cie_pkg::MAG_MASK)) |
                    (g & cie_pkg::SIGN_MASK);
            cie_pkg::OP_SRA: res = 16'($signed(g) >>> sra_n);
            cie_pkg::OP_SLL: res = (ea > 16'd15) ? 16'd0 : (g << ea[3:0]);
            default:         res = (ea > 16'd15) ? 16'd0 : (g >> ea[3:0]);
          endcase
          regs_next[r3] = res;
          flag_next     = cie_pkg::flag_of(res);
        end
        cie_pkg::OP_CPA: begin
          if ((g ^ cie_pkg::SIGN_MASK) > (m ^ cie_pkg::SIGN_MASK)) flag_next = cie_pkg::FLAG_POS;
          else if (g == m) flag_next = cie_pkg::FLAG_ZERO;
          else flag_next = cie_pkg::FLAG_NEG;
        end
        cie_pkg::OP_CPL: begin
          if (g > m) flag_next = cie_pkg::FLAG_POS;
          else if (g == m) flag_next = cie_pkg::FLAG_ZERO;
          else flag_next = cie_pkg::FLAG_NEG;
        end
        cie_pkg::OP_JPZ, cie_pkg::OP_JMI, cie_pkg::OP_JNZ, cie_pkg::OP_JZE: begin
          if ((cur.opcode == cie_pkg::OP_JPZ &&
               (flag == cie_pkg::FLAG_POS || flag == cie_pkg::FLAG_ZERO)) ||
              (cur.opcode == cie_pkg::OP_JMI && flag == cie_pkg::FLAG_NEG) ||
              (cur.opcode == cie_pkg::OP_JNZ && flag != cie_pkg::FLAG_ZERO) ||
              (cur.opcode == cie_pkg::OP_JZE && flag == cie_pkg::FLAG_ZERO)) begin
            pc_next = ea;
            st_c    = cie_pkg::STAT_OK;
          end
        end
        cie_pkg::OP_JMP: begin
          exit_c  = (cur.adr_word == cie_pkg::EXIT_ADR);
          pc_next = ea;
          st_c    = cie_pkg::STAT_OK;
        end
        cie_pkg::OP_PUSH: begin
          regs_next[4] = sp_dec;
          wr_en        = in_mem(sp_dec);
          wr_addr      = sp_dec;
          wr_data      = ea;
        end
        cie_pkg::OP_POP: begin
          // A pop into the stack pointer increments the loaded word.
          regs_next[r3] = m;
          regs_next[4]  = ((rsel_wide == 16'(cie_pkg::SP_IDX)) ? m : regs[4]) + 16'd1;
          flag_next     = cie_pkg::flag_of(m);
        end
        cie_pkg::OP_CALL: begin
          regs_next[4] = sp_dec;
          wr_en        = in_mem(sp_dec);
          wr_addr      = sp_dec;
          wr_data      = pc_step;
          pc_next      = ea;
          st_c         = cie_pkg::STAT_OK;
        end
        default: begin
          regs_next[4] = sp_inc;
          pc_next      = m;
          st_c         = cie_pkg::STAT_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      cur   <= q_item;
      ea    <= ea_c;
      g     <= g_c;
      rd_ok <= in_mem(rd_addr_c);
    end
    if (commit) begin
      status      <= st_c;
      next_pc     <= pc_next;
      flag_out    <= flag_next;
      exit_seen   <= exit_c;
      mem_written <= wr_en && (cur.req_type != cie_pkg::REQ_WRITE);
      mem_addr    <= (wr_en && cur.req_type != cie_pkg::REQ_WRITE) ? wr_addr : 16'd0;
      mem_data    <= (wr_en && cur.req_type != cie_pkg::REQ_WRITE) ? wr_data : 16'd0;
    end
    if (rst) begin
      state     <= ST_FETCH;
      out_valid <= 1'b0;
      flag      <= cie_pkg::FLAG_POS;
      pc        <= 16'd0;
      for (int i = 0; i < 5; i++) regs[i] <= 16'd0;
    end else begin
      unique case (state)
        ST_FETCH: if (q_valid) state <= ST_EXEC;
        ST_EXEC:  if (commit) state <= ST_FETCH;
        default:  state <= ST_FETCH;
      endcase
      if (commit) begin
        out_valid <= 1'b1;
        flag      <= flag_next;
        pc        <= pc_next;
        for (int i = 0; i < 5; i++) regs[i] <= regs_next[i];
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) commit |=> out_valid)
    else $error("executed request produced no result");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && mem_written |-> status != cie_pkg::STAT_BADOP && status != cie_pkg::STAT_BADREG)
    else $error("rejected instruction stored a word");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && exit_seen |-> !mem_written)
    else $error("exit jump stored a word");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) && q_valid |=> !q_ready)
    else $error("second request taken during execute");

endmodule

FILE: hw/rtl/comet_instruction_execute.sv
// Top level of the COMET execute unit: request front end and execute back end.
// Each request passes through the queue write, then the operand read, then the
// execute update into the result register; an output stall can hold it in execute.
// The back end takes a new request only after the last one has committed, since the
// synchronous operand read is followed by the register/memory update.
// Reset clears registers, flag, pc and queue; memory is undefined until written.
module comet_instruction_execute #(
  parameter int MEM_WORDS = cie_pkg::MEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  opcode,
  input  logic [3:0]  reg_sel,
  input  logic [3:0]  index_sel,
  input  logic [15:0] adr_word,
  input  logic [15:0] load_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] next_pc,
  output logic [1:0]  flag_out,
  output logic        exit_seen,
  output logic        mem_written,
  output logic [15:0] mem_addr,
  output logic [15:0] mem_data
);

  logic          q_valid, q_ready;
  cie_pkg::req_t q_item;

  cie_front u_front (
    .clk, .rst, .in_valid, .in_ready, .req_type, .opcode, .reg_sel,
    .index_sel, .adr_word, .load_data, .q_valid, .q_ready, .q_item
  );

  cie_back #(.MEM_WORDS(MEM_WORDS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item, .out_valid, .out_ready,
    .status, .next_pc, .flag_out, .exit_seen, .mem_written, .mem_addr, .mem_data
  );

endmodule

FILE: verif/comet_instruction_execute_checker.sv
`timescale 1ns / 100ps
// Result checker for the COMET execute unit: predicts each request and compares the results.
module comet_instruction_execute_checker #(
  parameter int MEM_WORDS = cie_pkg::MEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  opcode,
  input  logic [3:0]  reg_sel,
  input  logic [3:0]  index_sel,
  input  logic [15:0] adr_word,
  input  logic [15:0] load_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [15:0] next_pc,
  input  logic [1:0]  flag_out,
  input  logic        exit_seen,
  input  logic        mem_written,
  input  logic [15:0] mem_addr,
  input  logic [15:0] mem_data,
  output int          errors
);

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pc;
    logic [1:0]  flag;
    logic        exit_seen;
    logic        mem_written;
    logic [15:0] mem_addr;
    logic [15:0] mem_data;
  } exec_result_t;

  logic [15:0]  mem_shadow [MEM_WORDS];
  bit           wrote [65536];
  logic [15:0]  gregs [5];
  logic [1:0]   flag_q;
  logic [15:0]  pc_q;
  exec_result_t result_q [$];

  function automatic logic [15:0] read_word(input logic [15:0] a);
    if (int'(a) < MEM_WORDS) return mem_shadow[a];
    return 16'd0;
  endfunction

  function automatic void store_word(input logic [15:0] a, input logic [15:0] d,
                                     inout exec_result_t res);
    if (int'(a) < MEM_WORDS) begin
      mem_shadow[a] = d;
      wrote[a] = 1'b1;
      res.mem_written = 1'b1;
      res.mem_addr = a;
      res.mem_data = d;
    end
  endfunction

  function automatic void load_reg(input logic [3:0] r, input logic [15:0] v);
    gregs[r] = v;
    flag_q = cie_pkg::flag_of(v);
  endfunction

  function automatic logic [1:0] advance_pc();
    if (int'(pc_q) < MEM_WORDS) begin
      pc_q = pc_q + 16'd2;
      return cie_pkg::STAT_OK;
    end
    return cie_pkg::STAT_PCOUT;
  endfunction

  function automatic logic [1:0] take_branch(input bit taken, input logic [15:0] ea);
    if (taken) begin
      pc_q = ea;
      return cie_pkg::STAT_OK;
    end
    return advance_pc();
  endfunction

  function automatic logic [15:0] shifted(input logic [7:0] op, input logic [15:0] g,
                                          input logic [15:0] cnt);
    logic [31:0] w;
    int n;
    w = {16'd0, g};
    n = int'(cnt);
    case (op)
      cie_pkg::OP_SLA:
        return (n >= 16 ? 16'd0 : 16'((w << n) & {16'd0, cie_pkg::MAG_MASK})) |
               (g & cie_pkg::SIGN_MASK);
      cie_pkg::OP_SRA: begin
        if (n > 15) n = 15;
        if (g[15]) return 16'((w >> n) | ((32'hFFFF << (16 - n)) & 32'hFFFF));
        return 16'(w >> n);
      end
      cie_pkg::OP_SLL: return n >= 16 ? 16'd0 : 16'(w << n);
      default: return n >= 16 ? 16'd0 : 16'(w >> n);
    endcase
  endfunction

  function automatic exec_result_t execute_request(
    input logic rt, input logic [7:0] op, input logic [3:0] r, input logic [3:0] x,
    input logic [15:0] adr, input logic [15:0] ld);
    exec_result_t res;
    bit known, uses_r, uses_x;
    logic [15:0] ea, g, m, sp, a, b;
    res = '0;
    known = 1'b1;
    uses_r = 1'b0;
    uses_x = 1'b1;
    g = 16'd0;
    if (rt == cie_pkg::REQ_WRITE) begin
      if (int'(adr) < MEM_WORDS) begin
        mem_shadow[adr] = ld;
        wrote[adr] = 1'b1;
      end
    end else begin
      case (op)
        cie_pkg::OP_LD, cie_pkg::OP_ST, cie_pkg::OP_LEA, cie_pkg::OP_ADD, cie_pkg::OP_SUB,
        cie_pkg::OP_AND, cie_pkg::OP_OR, cie_pkg::OP_EOR, cie_pkg::OP_CPA, cie_pkg::OP_CPL,
        cie_pkg::OP_SLA, cie_pkg::OP_SRA, cie_pkg::OP_SLL, cie_pkg::OP_SRL: uses_r = 1'b1;
        cie_pkg::OP_POP: begin
          uses_r = 1'b1;
          uses_x = 1'b0;
        end
        cie_pkg::OP_RET: uses_x = 1'b0;
        cie_pkg::OP_JPZ, cie_pkg::OP_JMI, cie_pkg::OP_JNZ, cie_pkg::OP_JZE, cie_pkg::OP_JMP,
        cie_pkg::OP_PUSH, cie_pkg::OP_CALL: ;
        default: known = 1'b0;
      endcase
      if (!known) res.status = cie_pkg::STAT_BADOP;
      else if ((uses_r && r > 4) || (uses_x && x > 4)) res.status = cie_pkg::STAT_BADREG;
      else begin
        ea = adr;
        if (uses_x && x >= 1) ea = adr + gregs[x];
        if (uses_r) g = gregs[r];
        m = read_word(ea);
        case (op)
          cie_pkg::OP_LD: begin
            gregs[r] = m;
            res.status = advance_pc();
          end
          cie_pkg::OP_ST: begin
            store_word(ea, g, res);
            res.status = advance_pc();
          end
          cie_pkg::OP_LEA: begin load_reg(r, ea); res.status = advance_pc(); end
          cie_pkg::OP_ADD: begin load_reg(r, g + m); res.status = advance_pc(); end
          cie_pkg::OP_SUB: begin load_reg(r, g - m); res.status = advance_pc(); end
          cie_pkg::OP_AND: begin load_reg(r, g & m); res.status = advance_pc(); end
          cie_pkg::OP_OR:  begin load_reg(r, g | m); res.status = advance_pc(); end
          cie_pkg::OP_EOR: begin load_reg(r, g ^ m); res.status = advance_pc(); end
          cie_pkg::OP_CPA: begin
            a = g ^ cie_pkg::SIGN_MASK;
            b = m ^ cie_pkg::SIGN_MASK;
            flag_q = a > b ? cie_pkg::FLAG_POS :
                     (a == b ? cie_pkg::FLAG_ZERO : cie_pkg::FLAG_NEG);
            res.status = advance_pc();
          end
          cie_pkg::OP_CPL: begin
            flag_q = g > m ? cie_pkg::FLAG_POS :
                     (g == m ? cie_pkg::FLAG_ZERO : cie_pkg::FLAG_NEG);
            res.status = advance_pc();
          end
          cie_pkg::OP_SLA, cie_pkg::OP_SRA, cie_pkg::OP_SLL, cie_pkg::OP_SRL: begin
            load_reg(r, shifted(op, g, ea));
            res.status = advance_pc();
          end
          cie_pkg::OP_JPZ:
            res.status = take_branch(flag_q == cie_pkg::FLAG_POS ||
                                     flag_q == cie_pkg::FLAG_ZERO, ea);
          cie_pkg::OP_JMI: res.status = take_branch(flag_q == cie_pkg::FLAG_NEG, ea);
          cie_pkg::OP_JNZ: res.status = take_branch(flag_q != cie_pkg::FLAG_ZERO, ea);
          cie_pkg::OP_JZE: res.status = take_branch(flag_q == cie_pkg::FLAG_ZERO, ea);
          cie_pkg::OP_JMP: begin
            res.exit_seen = (adr == cie_pkg::EXIT_ADR);
            pc_q = ea;
          end
          cie_pkg::OP_PUSH: begin
            sp = gregs[cie_pkg::SP_IDX] - 16'd1;
            gregs[cie_pkg::SP_IDX] = sp;
            store_word(sp, ea, res);
            res.status = advance_pc();
          end
          cie_pkg::OP_POP: begin
            // load first, then bump the stack pointer (also when r is the SP)
            load_reg(r, read_word(gregs[cie_pkg::SP_IDX]));
            gregs[cie_pkg::SP_IDX] = gregs[cie_pkg::SP_IDX] + 16'd1;
            res.status = advance_pc();
          end
          cie_pkg::OP_CALL: begin
            sp = gregs[cie_pkg::SP_IDX] - 16'd1;
            gregs[cie_pkg::SP_IDX] = sp;
            store_word(sp, pc_q + 16'd2, res);
            pc_q = ea;
          end
          default: begin
            sp = gregs[cie_pkg::SP_IDX];
            gregs[cie_pkg::SP_IDX] = sp + 16'd1;
            pc_q = read_word(sp);
          end
        endcase
      end
    end
    res.pc = pc_q;
    res.flag = flag_q;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  initial begin
    errors = 0;
    for (int i = 0; i < 65536; i++) wrote[i] = 1'b0;
  end

  always @(posedge clk) begin
    exec_result_t exp_r;
    if (rst) begin
      for (int i = 0; i < 5; i++) gregs[i] = 16'd0;
      flag_q = cie_pkg::FLAG_POS;
      pc_q = 16'd0;
      result_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: result with none expected: status %h pc %h", $time, status,
                   next_pc);
          errors++;
        end else begin
          exp_r = result_q.pop_front();
          check_field("status", 16'(exp_r.status), 16'(status));
          check_field("next_pc", exp_r.pc, next_pc);
          check_field("flag_out", 16'(exp_r.flag), 16'(flag_out));
          check_field("exit_seen", 16'(exp_r.exit_seen), 16'(exit_seen));
          check_field("mem_written", 16'(exp_r.mem_written), 16'(mem_written));
          check_field("mem_addr", exp_r.mem_addr, mem_addr);
          check_field("mem_data", exp_r.mem_data, mem_data);
        end
      end
      if (in_valid && in_ready)
        result_q.push_back(execute_request(req_type, opcode, reg_sel, index_sel, adr_word,
                                           load_data));
    end
  end

endmodule

FILE: verif/tb_comet_instruction_execute.sv
`timescale 1ns / 100ps
// Testbench top for the COMET execute unit: clock, reset, request stimulus and verdict.
module tb_comet_instruction_execute;

  localparam logic [7:0] OPS [23] = '{cie_pkg::OP_LD, cie_pkg::OP_ST, cie_pkg::OP_LEA,
    cie_pkg::OP_ADD, cie_pkg::OP_SUB, cie_pkg::OP_AND, cie_pkg::OP_OR, cie_pkg::OP_EOR,
    cie_pkg::OP_CPA, cie_pkg::OP_CPL, cie_pkg::OP_SLA, cie_pkg::OP_SRA, cie_pkg::OP_SLL,
    cie_pkg::OP_SRL, cie_pkg::OP_JPZ, cie_pkg::OP_JMI, cie_pkg::OP_JNZ, cie_pkg::OP_JZE,
    cie_pkg::OP_JMP, cie_pkg::OP_PUSH, cie_pkg::OP_POP, cie_pkg::OP_CALL, cie_pkg::OP_RET};

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        req_type;
  logic [7:0]  opcode;
  logic [3:0]  reg_sel;
  logic [3:0]  index_sel;
  logic [15:0] adr_word;
  logic [15:0] load_data;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [15:0] next_pc;
  logic [1:0]  flag_out;
  logic        exit_seen;
  logic        mem_written;
  logic [15:0] mem_addr;
  logic [15:0] mem_data;
  int          errors;
  bit          calm;

  comet_instruction_execute u_dut (.*);
  comet_instruction_execute_checker u_chk (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Hold each request until accepted; gaps are drawn per request.
  task automatic send_request(input logic rt, input logic [7:0] op, input logic [3:0] r,
                              input logic [3:0] x, input logic [15:0] adr,
                              input logic [15:0] ld);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    opcode <= op;
    reg_sel <= r;
    index_sel <= x;
    adr_word <= adr;
    load_data <= ld;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic ensure_written(input logic [15:0] a);
    if (!u_chk.wrote[a]) send_request(cie_pkg::REQ_WRITE, 8'($urandom), 4'($urandom),
                                      4'($urandom), a, 16'($urandom));
  endtask

  // Fill any operand word of a known opcode with a valid index not yet written, then issue the instruction.
  task automatic run_instr(input logic [7:0] op, input logic [3:0] r, input logic [3:0] x,
                           input logic [15:0] adr);
    bit known;
    bit no_index;
    known = 1'b0;
    foreach (OPS[i]) if (OPS[i] == op) known = 1'b1;
    no_index = (op == cie_pkg::OP_POP || op == cie_pkg::OP_RET);
    if (known) begin
      if (no_index || x == 0) ensure_written(adr);
      else if (x <= 4) ensure_written(adr + u_chk.gregs[x]);
      if (no_index) ensure_written(u_chk.gregs[cie_pkg::SP_IDX]);
    end
    send_request(1'b1, op, r, x, adr, 16'($urandom));
  endtask

  initial begin
    out_ready <= 1'b0;
    @(negedge clk);
    forever begin
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    logic [7:0]  op;
    logic [3:0]  r, x;
    logic [15:0] adr;
    int          pick;
    calm = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = 1'b0;
    opcode = 8'd0;
    reg_sel = 4'd0;
    index_sel = 4'd0;
    adr_word = 16'd0;
    load_data = 16'd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: field extremes, every opcode, the corner cases
    send_request(cie_pkg::REQ_WRITE, 8'hFF, 4'hF, 4'hF, 16'hFFFF, 16'hFFFF);
    send_request(cie_pkg::REQ_WRITE, 8'h00, 4'h0, 4'h0, 16'h0000, 16'h8000);
    run_instr(cie_pkg::OP_LD, 4'd1, 4'd0, 16'h0000);
    run_instr(cie_pkg::OP_LEA, 4'd2, 4'd1, 16'h7FFF);
    run_instr(cie_pkg::OP_ADD, 4'd1, 4'd2, 16'h0000);
    run_instr(cie_pkg::OP_SLA, 4'd1, 4'd0, 16'd16);
    run_instr(cie_pkg::OP_SRA, 4'd1, 4'd0, 16'hFFFF);
    run_instr(cie_pkg::OP_SLL, 4'd2, 4'd0, 16'd15);
    run_instr(cie_pkg::OP_SRL, 4'd2, 4'd0, 16'd0);
    run_instr(cie_pkg::OP_ST, 4'd4, 4'd4, 16'h1234);
    run_instr(cie_pkg::OP_PUSH, 4'd0, 4'd3, 16'h0042);
    run_instr(cie_pkg::OP_POP, 4'd4, 4'hF, 16'h0000);
    run_instr(cie_pkg::OP_CALL, 4'd0, 4'd0, 16'h0100);
    run_instr(cie_pkg::OP_RET, 4'hF, 4'hF, 16'h0000);
    run_instr(cie_pkg::OP_JMP, 4'd0, 4'd0, cie_pkg::EXIT_ADR);
    run_instr(cie_pkg::OP_LD, 4'd5, 4'd0, 16'h0000);
    run_instr(cie_pkg::OP_ADD, 4'd0, 4'hF, 16'h0000);
    run_instr(8'hFF, 4'd0, 4'd0, 16'h0000);
    foreach (OPS[i]) run_instr(OPS[i], 4'($urandom_range(0, 4)), 4'($urandom_range(0, 4)),
                               16'($urandom_range(0, 63)));

    for (int n = 0; n < 320; n++) begin
      if (n % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_request(cie_pkg::REQ_WRITE, 8'($urandom), 4'($urandom), 4'($urandom),
                     16'($urandom_range(0, 63)), 16'($urandom));
        continue;
      end
      op = ($urandom_range(0, 99) < 88) ? OPS[$urandom_range(0, 22)] : 8'($urandom);
      r = ($urandom_range(0, 9) < 9) ? 4'($urandom_range(0, 4)) : 4'($urandom);
      x = ($urandom_range(0, 9) < 4) ? 4'd0 :
          (($urandom_range(0, 9) < 9) ? 4'($urandom_range(1, 4)) : 4'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 45) adr = 16'($urandom_range(0, 63));
      else if (pick < 60) adr = 16'($urandom_range(0, 20));
      else if (pick < 70) adr = cie_pkg::EXIT_ADR;
      else if (pick < 80) adr = 16'($urandom_range(16'hFFC0, 16'hFFFF));
      else adr = 16'($urandom);
      run_instr(op, r, x, adr);
    end

    in_valid <= 1'b0;
    while (u_chk.result_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/cie_pkg.sv
hw/rtl/cie_ram.sv
hw/rtl/cie_front.sv
hw/rtl/cie_back.sv
hw/rtl/comet_instruction_execute.sv
verif/comet_instruction_execute_checker.sv
verif/tb_comet_instruction_execute.sv
